/* rtl/sorted_cycle_timer_queue_defines.svh */
// Assertion macros for the sorted cycle timer queue.
`ifndef SORTED_CYCLE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_CYCLE_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define SCTQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCTQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCTQ_ASSERT(label, clk, rst, prop, msg)
`define SCTQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/sctq_pkg.sv */
// Shared types and constants for the sorted cycle timer queue.
`timescale 1ns / 1ps
package sctq_pkg;
  localparam int SLOTS_DEF = 32;
  localparam int KEY_BITS_DEF = 8;
  localparam int KEY_W = 8;
  localparam int DLY_W = 32;
  localparam int CYC_W = 64;
  localparam logic [63:0] EMPTY_SLEEP = 64'd1000;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_PROCESS = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [KEY_W-1:0] timer_key;
    logic [DLY_W-1:0] delay;
    logic [CYC_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic status;
    logic fired;
    logic [KEY_W-1:0] fired_key;
    logic [CYC_W-1:0] fired_deadline;
    logic [CYC_W-1:0] remaining;
    logic [CYC_W-1:0] sleep_cycles;
    logic [CYC_W-1:0] run_span;
    logic last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic scan;      // advance scan index
    logic shift;     // perform move step
    logic fire;      // stage fire result
    logic summary;   // stage summary result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic head_due;
  } dp_sts_t;
endpackage

/* rtl/sctq_if.sv */
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface sctq_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sctq_datapath.sv */
// Entry storage, key search, sorted move and result formation.
`timescale 1ns / 1ps
module sctq_datapath #(
  parameter int SLOTS = 32,
  parameter int KEY_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  sctq_pkg::in_item_t in_item,
  input  logic [63:0] run_limit,
  input  sctq_pkg::dp_cmd_t cmd,
  output sctq_pkg::dp_sts_t sts,
  output sctq_pkg::out_item_t out_item
);
  import sctq_pkg::*;
  localparam int IW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [1:0] PH_REMOVE = 2'd0;
  localparam logic [1:0] PH_INSERT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [CYC_W-1:0] dl [SLOTS];
  logic [KEY_BITS-1:0] ky [SLOTS];
  logic [IW-1:0] count;
  logic [IW-1:0] idx;
  logic [IW-1:0] found;
  logic hit;
  logic [1:0] op;
  logic [KEY_BITS-1:0] key;
  logic [CYC_W-1:0] now;
  logic [CYC_W-1:0] new_dl;
  logic full_st;
  logic [1:0] phase;
  logic [IW-1:0] ins_pos;

  logic [CYC_W-1:0] slp;
  logic [CYC_W-1:0] run;

  always_comb begin
    slp = EMPTY_SLEEP;
    if (count != '0) begin
      slp = (dl[0] > now) ? dl[0] - now : '0;
    end
    run = (run_limit >= slp) ? slp : run_limit;
    if (run == '0) begin
      run = 64'd1;
    end
  end

  assign sts.scan_done = hit || (idx >= count);
  assign sts.head_due = (count != '0) && (dl[0] <= now);
  assign sts.shift_done = (phase == PH_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      phase <= PH_DONE;
    end else begin
      if (cmd.load) begin
        op <= in_item.opcode;
        key <= KEY_BITS'(in_item.timer_key);
        now <= in_item.now;
        new_dl <= in_item.now + {32'd0, in_item.delay};
        idx <= '0;
        hit <= 1'b0;
        full_st <= 1'b0;
        phase <= PH_REMOVE;
      end
      if (cmd.scan && !hit && idx < count) begin
        if (ky[idx[AW-1:0]] == key) begin
          hit <= 1'b1;
          found <= idx;
        end
        idx <= idx + IW'(1);
      end
      if (cmd.shift) begin
        if (phase == PH_REMOVE) begin
          // drop matched entry
          if (hit && (op == OP_REGISTER || op == OP_CANCEL)) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
              if (IW'(i) >= found) begin
                dl[i] <= dl[i+1];
                ky[i] <= ky[i+1];
              end
            end
            count <= count - IW'(1);
          end
          phase <= (op == OP_REGISTER) ? PH_INSERT : PH_DONE;
        end else if (phase == PH_INSERT) begin
          if (count >= IW'(SLOTS)) begin
            full_st <= 1'b1;
          end else begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
              if (IW'(i) > ins_pos) begin
                dl[i] <= dl[i-1 < 0 ? 0 : i-1];
                ky[i] <= ky[i-1 < 0 ? 0 : i-1];
              end else if (IW'(i) == ins_pos) begin
                dl[i] <= new_dl;
                ky[i] <= key;
              end
            end
            count <= count + IW'(1);
          end
          phase <= PH_DONE;
        end
      end
      if (cmd.fire) begin
        out_item <= '{status: 1'b0, fired: 1'b1,
                      fired_key: KEY_W'(ky[0]), fired_deadline: dl[0],
                      remaining: '0, sleep_cycles: '0,
                      run_span: 64'd1, last: 1'b0};
        for (int i = 0; i < SLOTS - 1; i++) begin
          dl[i] <= dl[i+1];
          ky[i] <= ky[i+1];
        end
        count <= count - IW'(1);
      end
      if (cmd.summary) begin
        out_item <= '{status: full_st, fired: 1'b0, fired_key: '0,
                      fired_deadline: '0,
                      remaining: (op == OP_STATUS && hit)
                                 ? 64'd1 + (dl[found[AW-1:0]] - now) : '0,
                      sleep_cycles: slp, run_span: run, last: 1'b1};
      end
    end
  end

  // insert position: first slot whose deadline exceeds the new one
  always_comb begin
    ins_pos = count;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (IW'(i) < count && dl[i] > new_dl) begin
        ins_pos = IW'(i);
      end
    end
  end
endmodule

/* rtl/sctq_ctrl.sv */
// Controller state machine sequencing search, update and result issue.
`timescale 1ns / 1ps
module sctq_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sctq_pkg::dp_sts_t sts,
  input  logic [1:0] opcode_q,
  output sctq_pkg::dp_cmd_t cmd
);
  import sctq_pkg::*;
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_MOVE  = 5'b00100,
    S_PROC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;
  state_t state, state_next;
  logic last_out, last_out_next;
  logic ov, ov_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = ov;

  always_comb begin
    state_next = state;
    last_out_next = last_out;
    ov_next = ov;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (opcode_q == OP_PROCESS) begin
          state_next = S_PROC;
        end else if (sts.scan_done) begin
          state_next = S_MOVE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_MOVE: begin
        if (sts.shift_done) begin
          cmd.summary = 1'b1;
          ov_next = 1'b1;
          last_out_next = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_PROC: begin
        if (sts.head_due) begin
          cmd.fire = 1'b1;
          last_out_next = 1'b0;
        end else begin
          cmd.summary = 1'b1;
          last_out_next = 1'b1;
        end
        ov_next = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          ov_next = 1'b0;
          state_next = last_out ? S_IDLE : S_PROC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov <= 1'b0;
      last_out <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
      last_out <= last_out_next;
    end
  end
endmodule

/* rtl/sorted_cycle_timer_queue.sv */
// Cancel/status: after accept, slots are scanned (at most the entry count, stopping at a key
// match), then a remove step runs and the result is issued; register adds an insert step.
// Process issues one result per due head entry, each popped, then a final summary; each waits for out_ready.
// One transaction in flight; next input taken in the cycle after the final result leaves.
// Synchronous active-high reset empties the queue and sets run_limit to one.
`timescale 1ns / 1ps
`include "sorted_cycle_timer_queue_defines.svh"
module sorted_cycle_timer_queue #(
  parameter int SLOTS = sctq_pkg::SLOTS_DEF,
  parameter int KEY_BITS = sctq_pkg::KEY_BITS_DEF
) (
  input logic clk,
  input logic rst,
  sctq_if.sink in_ch,
  sctq_if.source out_ch,
  input logic cfg_we,
  input logic [63:0] cfg_wdata
);
  import sctq_pkg::*;
  logic [63:0] run_limit;
  dp_cmd_t cmd;
  dp_sts_t sts;
  in_item_t in_item;
  logic [1:0] opq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_limit <= 64'd1;
      opq <= OP_REGISTER;
    end else begin
      if (cfg_we) begin
        run_limit <= cfg_wdata;
      end
      if (cmd.load) begin
        opq <= in_ch.payload.opcode;
      end
    end
  end

  assign in_item = in_ch.payload;

  sctq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts),
    .opcode_q(opq), .cmd(cmd)
  );

  sctq_datapath #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .run_limit(run_limit),
    .cmd(cmd), .sts(sts), .out_item(out_ch.payload)
  );

  `SCTQ_ASSERT(a_no_accept_busy, clk, rst, out_ch.valid |-> !in_ch.ready, "accept while busy")
  `SCTQ_ASSERT(a_run_nonzero, clk, rst, out_ch.valid |-> out_ch.payload.run_span != '0, "run zero")
  `SCTQ_ASSERT_RST(a_reset_idle, clk, rst |=> !out_ch.valid, "valid after reset")
endmodule
